[sv/gbts_pkg.sv]
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared types and codes for the gap-buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam logic [2:0] CMD_INSERT  = 3'd0;
  localparam logic [2:0] CMD_BACK    = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_MOVE_L  = 3'd3;
  localparam logic [2:0] CMD_MOVE_R  = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_BOUND = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_in;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] char_out;
    logic [8:0] cursor;
    logic [8:0] text_length;
  } out_item_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_FINISH
  } fsm_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec_now;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_mem;
  } dp_stat_t;

endpackage

[sv/gbts_ctrl.sv]
// ----------------------------------------------------------------------------
// gbts_ctrl
// Command sequencer: commands that need no store byte finish at accept,
// store reads go through a finishing state before their result.
// ----------------------------------------------------------------------------
module gbts_ctrl
  import gbts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_stat_t   dp_stat,
  output ctrl_cmd_t  ctrl_cmd,
  output logic       busy
);

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl_cmd  = '0;
    case (state_r)
      FSM_IDLE: begin
        if (start) begin
          ctrl_cmd.accept = 1'b1;
          if (dp_stat.need_mem) begin
            state_nxt = FSM_FINISH;
          end else begin
            ctrl_cmd.exec_now = 1'b1;
          end
        end
      end
      FSM_FINISH: begin
        ctrl_cmd.finish = 1'b1;
        state_nxt       = FSM_IDLE;
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  assign busy = (state_r == FSM_FINISH);

endmodule

[sv/gbts_dp.sv]
// ----------------------------------------------------------------------------
// gbts_dp
// Gap pointers, byte store and result register.
// ----------------------------------------------------------------------------
module gbts_dp
  import gbts_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  ctrl_cmd_t  ctrl_cmd,
  output dp_stat_t   dp_stat,
  output logic       out_strobe,
  output out_item_t  out_item
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int LW = (PW > 9) ? PW : 9;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rdata_r;
  logic [PW-1:0] gs_r, gs_nxt;
  logic [PW-1:0] ge_r, ge_nxt;
  logic [2:0]    op_r;
  logic          out_strobe_r;
  out_item_t     out_r, out_nxt;

  logic          can_ins, can_back, can_fwd, idx_ok;
  logic [PW-1:0] len;
  logic [LW-1:0] pos;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [LW-1:0] cur_w, len_w;

  assign can_ins  = gs_r < ge_r;
  assign can_back = gs_r != '0;
  assign can_fwd  = ge_r != CAP_P;
  assign len      = gs_r + (CAP_P - ge_r);
  assign idx_ok   = LW'(in_item.read_index) < LW'(len);
  // logical index to physical slot, skipping the gap
  assign pos      = (LW'(in_item.read_index) < LW'(gs_r)) ? LW'(in_item.read_index)
                  : LW'(in_item.read_index) - LW'(gs_r) + LW'(ge_r);

  always_comb begin
    dp_stat.need_mem = 1'b0;
    rd_addr          = pos[AW-1:0];
    case (in_item.cmd)
      CMD_MOVE_L: begin
        dp_stat.need_mem = can_back;
        rd_addr          = AW'(gs_r - PW'(1));
      end
      CMD_MOVE_R: begin
        dp_stat.need_mem = can_fwd;
        rd_addr          = ge_r[AW-1:0];
      end
      CMD_READ: begin
        dp_stat.need_mem = idx_ok;
      end
      default: begin
        dp_stat.need_mem = 1'b0;
      end
    endcase
  end

  always_comb begin
    gs_nxt           = gs_r;
    ge_nxt           = ge_r;
    wr_en            = 1'b0;
    wr_addr          = gs_r[AW-1:0];
    wr_data          = in_item.char_in;
    out_nxt.status   = ST_BOUND;
    out_nxt.char_out = 8'd0;
    if (ctrl_cmd.exec_now) begin
      case (in_item.cmd)
        CMD_INSERT: begin
          if (can_ins) begin
            wr_en          = 1'b1;
            gs_nxt         = gs_r + PW'(1);
            out_nxt.status = ST_DONE;
          end else begin
            out_nxt.status = ST_FULL;
          end
        end
        CMD_BACK: begin
          if (can_back) begin
            gs_nxt         = gs_r - PW'(1);
            out_nxt.status = ST_DONE;
          end
        end
        CMD_DELETE: begin
          if (can_fwd) begin
            ge_nxt         = ge_r + PW'(1);
            out_nxt.status = ST_DONE;
          end
        end
        CMD_READ: begin
          out_nxt.status = ST_RANGE;
        end
        default: begin
          out_nxt.status = ST_BOUND;
        end
      endcase
    end else if (ctrl_cmd.finish) begin
      out_nxt.status = ST_DONE;
      case (op_r)
        CMD_MOVE_L: begin
          wr_en   = 1'b1;
          wr_addr = AW'(ge_r - PW'(1));
          wr_data = rdata_r;
          gs_nxt  = gs_r - PW'(1);
          ge_nxt  = ge_r - PW'(1);
        end
        CMD_MOVE_R: begin
          wr_en   = 1'b1;
          wr_addr = gs_r[AW-1:0];
          wr_data = rdata_r;
          gs_nxt  = gs_r + PW'(1);
          ge_nxt  = ge_r + PW'(1);
        end
        default: begin
          out_nxt.char_out = rdata_r;
        end
      endcase
    end
    cur_w               = LW'(gs_nxt);
    len_w               = LW'(gs_nxt + (CAP_P - ge_nxt));
    out_nxt.cursor      = cur_w[8:0];
    out_nxt.text_length = len_w[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r         <= '0;
      ge_r         <= CAP_P;
      out_strobe_r <= 1'b0;
    end else begin
      gs_r         <= gs_nxt;
      ge_r         <= ge_nxt;
      out_strobe_r <= ctrl_cmd.exec_now | ctrl_cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.accept) begin
      op_r <= in_item.cmd;
    end
    if (ctrl_cmd.exec_now | ctrl_cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  // single-port style store: read only at accept, write at insert or at a move's finish
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl_cmd.accept & dp_stat.need_mem) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

[sv/gap_buffer_text_store.sv]
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Fixed-capacity gap-buffer text store with a command interface.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each command gives
// exactly one result, shown on out_item for one cycle with out_strobe high,
// and the receiver cannot hold it off. Insert, backspace, delete, and any
// command that is rejected finish in the cycle they are taken: busy stays low
// and the result appears in the next cycle, so these run at one per cycle.
// Move left, move right and an in-range read need a byte from the store,
// whose read data is registered; they hold busy high through a finishing
// state, in which the result is registered, and no new command is taken
// until busy falls. The store contents need no clearing after reset.
module gap_buffer_text_store
  import gbts_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  gbts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .dp_stat  (dp_stat),
    .ctrl_cmd (ctrl_cmd),
    .busy     (busy)
  );

  gbts_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .ctrl_cmd   (ctrl_cmd),
    .dp_stat    (dp_stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  a_busy_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted word");

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_strobe && !busy))
    else $error("finishing cycle gave no result");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted word neither finished nor went busy");

endmodule
